### src/ftws_pkg.sv
// Package for the frame-time window statistics block.
// Holds field widths, the controller command and status structs.
// No dependencies.
package ftws_pkg;

	localparam int TS_BITS    = 32;
	localparam int FIELD_BITS = 16;
	localparam int SUM_BITS   = 21;

	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

	typedef struct packed {
		logic capture;
		logic write;
		logic scan_step;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_busy;
	} ctrl_status_t;

endpackage

### src/ftws_ifs.sv
// Valid/ready channel interfaces for the frame-time window statistics block.
// Depends on ftws_pkg for the field widths.
interface ftws_in_if;
	logic                       valid;
	logic                       ready;
	logic [ftws_pkg::TS_BITS-1:0] timestamp_ms;

	modport source (output valid, output timestamp_ms, input ready);
	modport sink (input valid, input timestamp_ms, output ready);
endinterface

interface ftws_out_if;
	logic                           valid;
	logic                           ready;
	logic [ftws_pkg::FIELD_BITS-1:0] frame_ms;
	logic [ftws_pkg::SUM_BITS-1:0]   window_sum;
	logic [ftws_pkg::FIELD_BITS-1:0] window_min;
	logic [ftws_pkg::FIELD_BITS-1:0] window_max;

	modport source (output valid, output frame_ms, output window_sum,
		output window_min, output window_max, input ready);
	modport sink (input valid, input frame_ms, input window_sum,
		input window_min, input window_max, output ready);
endinterface

### src/ftws_ctrl.sv
// Controller state machine for the frame-time window statistics block.
// Sequences capture, ring write, window scan and result load; uses ftws_pkg.
module ftws_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ftws_pkg::ctrl_status_t status,
	output ftws_pkg::ctrl_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WRITE = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_FLUSH = 3'd3;
	localparam logic [2:0] S_PUSH  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = S_FLUSH;
				end
			end
			// The last read word is folded into the statistics here.
			S_FLUSH: begin
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/ftws_datapath.sv
// Datapath for the frame-time window statistics block: frame-time
// subtraction, sample ring memory, serial scan and output register. Uses ftws_pkg.
module ftws_datapath #(
	parameter int WINDOW      = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ftws_pkg::ctrl_cmd_t                 cmd,
	output ftws_pkg::ctrl_status_t              status,
	input  logic [ftws_pkg::TS_BITS-1:0]        timestamp_ms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ftws_pkg::FIELD_BITS-1:0]     frame_ms,
	output logic [ftws_pkg::SUM_BITS-1:0]       window_sum,
	output logic [ftws_pkg::FIELD_BITS-1:0]     window_min,
	output logic [ftws_pkg::FIELD_BITS-1:0]     window_max
);

	localparam int IDX_BITS  = $clog2(WINDOW);
	localparam int FILL_BITS = $clog2(WINDOW + 1);
	localparam int ACC_BITS  = ((SAMPLE_BITS > ftws_pkg::SUM_BITS) ?
		SAMPLE_BITS : ftws_pkg::SUM_BITS) + 1;
	localparam logic [ftws_pkg::TS_BITS-1:0] SAMPLE_MAX =
		ftws_pkg::TS_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

	logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];

	logic [ftws_pkg::TS_BITS-1:0] stamp_q;
	logic [ftws_pkg::TS_BITS-1:0] last_stamp_q;
	logic [SAMPLE_BITS-1:0]       sample_q;
	logic [IDX_BITS-1:0]          write_slot_q;
	logic [FILL_BITS-1:0]         fill_level_q;
	logic [IDX_BITS-1:0]          scan_idx_q;
	logic [SAMPLE_BITS-1:0]       rd_data_s1;
	logic                         rd_vld_s1;
	logic [ftws_pkg::SUM_BITS-1:0] sum_q;
	logic [SAMPLE_BITS-1:0]       min_q;
	logic [SAMPLE_BITS-1:0]       max_q;

	logic [ftws_pkg::TS_BITS-1:0] diff;
	logic [SAMPLE_BITS-1:0]       sample_d;
	logic [ACC_BITS-1:0]          sum_ext;

	assign diff     = stamp_q - last_stamp_q;
	assign sample_d = (diff > SAMPLE_MAX) ? SAMPLE_MAX[SAMPLE_BITS-1:0]
		: diff[SAMPLE_BITS-1:0];
	assign sum_ext  = ACC_BITS'(sum_q) + ACC_BITS'(rd_data_s1);

	assign status.scan_last = (FILL_BITS'(scan_idx_q) + FILL_BITS'(1)) == fill_level_q;
	assign status.out_busy  = out_valid && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			stamp_q <= timestamp_ms;
		end
		if (cmd.write) begin
			sample_q               <= sample_d;
			ring_mem[write_slot_q] <= sample_d;
		end
		if (cmd.scan_step) begin
			rd_data_s1 <= ring_mem[scan_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= '0;
			write_slot_q <= '0;
			fill_level_q <= '0;
			scan_idx_q   <= '0;
			rd_vld_s1    <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.write) begin
				last_stamp_q <= stamp_q;
				scan_idx_q   <= '0;
				if (write_slot_q == IDX_BITS'(WINDOW - 1)) begin
					write_slot_q <= '0;
				end else begin
					write_slot_q <= write_slot_q + IDX_BITS'(1);
				end
				if (fill_level_q != FILL_BITS'(WINDOW)) begin
					fill_level_q <= fill_level_q + FILL_BITS'(1);
				end
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + IDX_BITS'(1);
			end
		end
	end

	// The running sum saturates at every step; as it only grows, this
	// matches saturating the full sum at the end.
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
		end else if (rd_vld_s1) begin
			if (sum_ext > ACC_BITS'(ftws_pkg::SUM_MAX)) begin
				sum_q <= ftws_pkg::SUM_MAX;
			end else begin
				sum_q <= sum_ext[ftws_pkg::SUM_BITS-1:0];
			end
			if (rd_data_s1 < min_q) begin
				min_q <= rd_data_s1;
			end
			if (rd_data_s1 > max_q) begin
				max_q <= rd_data_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Samples wider than the output fields are cut to their low bits.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			frame_ms   <= ftws_pkg::FIELD_BITS'(sample_q);
			window_sum <= sum_q;
			window_min <= ftws_pkg::FIELD_BITS'(min_q);
			window_max <= ftws_pkg::FIELD_BITS'(max_q);
		end
	end

endmodule

### src/frame_time_window_stats.sv
// Frame-time window statistics: frame time from successive timestamps, with
// sum, minimum and maximum over a ring of the last WINDOW samples.
// Each item runs capture, ring write, a serial scan of the filled entries through
// the single read port, a flush step and the result load, which waits while the
// output holds an untaken result. No new input is taken until the result is loaded.
// Reset clears the last stamp, slot and fill count; the ring is not cleared.
module frame_time_window_stats #(
	parameter int WINDOW      = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	ftws_in_if.sink         in_ch,
	ftws_out_if.source      out_ch
);

	ftws_pkg::ctrl_cmd_t    cmd;
	ftws_pkg::ctrl_status_t status;

	ftws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	ftws_datapath #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.timestamp_ms (in_ch.timestamp_ms),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.frame_ms     (out_ch.frame_ms),
		.window_sum   (out_ch.window_sum),
		.window_min   (out_ch.window_min),
		.window_max   (out_ch.window_max)
	);

endmodule

### bench/frame_time_window_stats_tb.sv
// Self-checking testbench for frame_time_window_stats: timestamps in, window statistics out.
// Depends on ftws_pkg, the channel interfaces in ftws_ifs.sv and the block itself.
module frame_time_window_stats_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN        = 32;
	localparam int SAMPLE_W   = 16;
	localparam logic [ftws_pkg::TS_BITS-1:0] SAMPLE_MAX = (32'd1 << SAMPLE_W) - 32'd1;
	localparam int HOLD_CYCLES = 900;
	localparam int DRAIN_CYCLES = 120;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [ftws_pkg::FIELD_BITS-1:0] frame_ms;
		logic [ftws_pkg::SUM_BITS-1:0]   window_sum;
		logic [ftws_pkg::FIELD_BITS-1:0] window_min;
		logic [ftws_pkg::FIELD_BITS-1:0] window_max;
	} stats_t;

	logic clk;
	logic arst_n;

	ftws_in_if  in_ch ();
	ftws_out_if out_ch ();

	frame_time_window_stats #(
		.WINDOW      (WIN),
		.SAMPLE_BITS (SAMPLE_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Stimulus and scoreboard state.
	logic [ftws_pkg::TS_BITS-1:0] stamp_queue [$];
	stats_t             stats_due [$];
	int                 stamps_queued = 0;
	int                 stamps_taken  = 0;
	int                 stats_checked = 0;
	int                 error_count   = 0;
	longint             cycle_count   = 0;
	bit                 in_taken      = 1'b0;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_seq      = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	// Shadow of the block's state.
	logic [ftws_pkg::TS_BITS-1:0] prev_stamp = '0;
	logic [SAMPLE_W-1:0] ring_model [WIN];
	int                  slot_model = 0;
	int                  fill_model = 0;

	logic [ftws_pkg::TS_BITS-1:0] gen_stamp = '0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic stats_t window_stats(logic [ftws_pkg::TS_BITS-1:0] stamp);
		logic [ftws_pkg::TS_BITS-1:0] delta;
		logic [SAMPLE_W-1:0] sample;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		longint unsigned     total;
		stats_t              r;
		delta = stamp - prev_stamp;
		sample = (delta > SAMPLE_MAX) ? SAMPLE_MAX[SAMPLE_W-1:0] : delta[SAMPLE_W-1:0];
		prev_stamp = stamp;
		ring_model[slot_model] = sample;
		slot_model = (slot_model == WIN - 1) ? 0 : slot_model + 1;
		if (fill_model < WIN)
			fill_model++;
		total = 0;
		lo = '1;
		hi = '0;
		// Only slots that have been written are scanned, starting from slot zero.
		for (int j = 0; j < fill_model; j++) begin
			total += ring_model[j];
			if (ring_model[j] < lo)
				lo = ring_model[j];
			if (ring_model[j] > hi)
				hi = ring_model[j];
		end
		if (total > ftws_pkg::SUM_MAX)
			total = ftws_pkg::SUM_MAX;
		r.frame_ms   = sample;
		r.window_sum = total[ftws_pkg::SUM_BITS-1:0];
		r.window_min = lo;
		r.window_max = hi;
		return r;
	endfunction

	// Rising edge: count cycles, record input transfers and check output transfers.
	always @(posedge clk) begin
		stats_t got;
		stats_t want;
		stats_t due;
		cycle_count++;
		if (arst_n) begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready) begin
				due = window_stats(in_ch.timestamp_ms);
				stats_due = {stats_due, due};
				stamps_taken++;
			end
			if (out_ch.valid && out_ch.ready) begin
				got.frame_ms   = out_ch.frame_ms;
				got.window_sum = out_ch.window_sum;
				got.window_min = out_ch.window_min;
				got.window_max = out_ch.window_max;
				if (stats_due.size() == 0) begin
					$error("unexpected result: frame_ms %0d window_sum %0d",
						got.frame_ms, got.window_sum);
					error_count++;
				end else begin
					want = stats_due[0];
					stats_due.delete(0);
					stats_checked++;
					if (got.frame_ms !== want.frame_ms) begin
						$error("frame_ms: expected %0d, actual %0d",
							want.frame_ms, got.frame_ms);
						error_count++;
					end
					if (got.window_sum !== want.window_sum) begin
						$error("window_sum: expected %0d, actual %0d",
							want.window_sum, got.window_sum);
						error_count++;
					end
					if (got.window_min !== want.window_min) begin
						$error("window_min: expected %0d, actual %0d",
							want.window_min, got.window_min);
						error_count++;
					end
					if (got.window_max !== want.window_max) begin
						$error("window_max: expected %0d, actual %0d",
							want.window_max, got.window_max);
						error_count++;
					end
				end
			end
		end
	end

	// Sender: offers the next timestamp once the current one has gone.
	always @(negedge clk) begin
		if (arst_n && (!in_ch.valid || in_taken)) begin
			if (stamp_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_ch.timestamp_ms <= stamp_queue[0];
				stamp_queue.delete(0);
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic queue_stamp(logic [ftws_pkg::TS_BITS-1:0] stamp);
		stamp_queue = {stamp_queue, stamp};
		stamps_queued++;
		gen_stamp = stamp;
	endtask

	// Mostly steady frame rates, with jumps, exact saturation edges, backward steps and noise.
	task automatic queue_random(int count);
		int pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 62)
				queue_stamp(gen_stamp + $urandom_range(1, 40));
			else if (pick < 72)
				queue_stamp(gen_stamp + $urandom_range(0, 70000));
			else if (pick < 78)
				queue_stamp(gen_stamp + $urandom_range(65534, 65537));
			else if (pick < 84)
				queue_stamp(gen_stamp - $urandom_range(1, 1000));
			else if (pick < 92)
				queue_stamp($urandom);
			else
				queue_stamp(gen_stamp + $urandom_range(0, 2));
		end
	endtask

	task automatic settle();
		while (stamps_taken != stamps_queued || stats_due.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.timestamp_ms = '0;
		out_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: the first item measures from zero, then zero, exact-limit,
		// saturating, backward and wrapping differences, and the field extremes.
		queue_stamp(32'd1000);
		queue_stamp(32'd1016);
		queue_stamp(32'd1016);
		queue_stamp(32'd1016 + 32'd65535);
		queue_stamp(gen_stamp + 32'd65536);
		queue_stamp(32'd500);
		queue_stamp(32'hFFFF_FFF0);
		queue_stamp(32'hFFFF_FFFF);
		queue_stamp(32'h0000_0010);
		queue_stamp(32'h0000_0000);
		queue_stamp(32'h7FFF_FFFF);
		queue_stamp(32'h8000_0000);
		queue_stamp(32'hFFFF_FFFF);
		queue_stamp(32'h5555_5555);
		queue_stamp(32'hAAAA_AAAA);
		for (int k = 0; k < 6; k++)
			queue_stamp(gen_stamp + 32'd16);
		settle();

		queue_random(250);
		settle();

		send_idle_pct = 78;
		queue_random(250);
		settle();

		send_idle_pct = 0;
		stall_pct = 78;
		queue_random(250);
		settle();

		send_idle_pct = 33;
		stall_pct = 33;
		queue_random(250);
		settle();

		// Long output hold-off while the sender keeps offering, so the input backs up.
		send_idle_pct = 0;
		stall_pct = 0;
		queue_random(60);
		hold_seq++;
		settle();

		// The sender pauses until every result is back, then a final burst.
		queue_random(40);
		settle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (stats_due.size() != 0) begin
			$error("%0d results still outstanding at the end", stats_due.size());
			error_count++;
		end
		$display("Sent %0d timestamps and checked %0d results, through idle and stall phases",
			stamps_taken, stats_checked);
		$display("and a %0d-cycle output hold-off; %0d mismatches.", HOLD_CYCLES, error_count);
		if (error_count == 0) begin
			$display("frame_time_window_stats_tb passed");
		end else begin
			$display("frame_time_window_stats_tb failed");
		end
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Timed out after %0d cycles.", cycle_count);
		$display("frame_time_window_stats_tb failed");
		$finish;
	end

endmodule

### filelist.f
src/ftws_pkg.sv
src/ftws_ifs.sv
src/ftws_ctrl.sv
src/ftws_datapath.sv
src/frame_time_window_stats.sv
bench/frame_time_window_stats_tb.sv
